// ===== src/imu_gyro_bias_calibrate_scale_macros.svh =====
// ----------------------------------------------------------------------------
// IMU gyro bias calibration: assertion macros
// Checks that evaluate at each rising edge while reset is released. They
// compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef IMU_GYRO_BIAS_CALIBRATE_SCALE_MACROS_SVH
`define IMU_GYRO_BIAS_CALIBRATE_SCALE_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define IMU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define IMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`else

`define IMU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IMU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/imu_gbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU gyro bias calibration: shared definitions
// Field widths, scale constants, operation and status codes, and the control
// bundle that drives the serial arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_gbcs_pkg;

	localparam int RAW_W          = 16;
	localparam int BIAS_FRAC_BITS = 8;
	localparam int COUNT_BITS     = 16;
	localparam int ACC_W          = 32;
	localparam int BIAS_W         = 24;
	localparam int ACCEL_W        = 20;
	localparam int GYRO_W         = 22;

	// Serial multiplier: a 25-bit signed operand walked one bit per cycle
	// against a 21-bit unsigned scale factor.
	localparam int MUL_N  = RAW_W + BIAS_FRAC_BITS + 1;
	localparam int MUL_KW = 21;
	localparam int MUL_PW = MUL_N + MUL_KW + 1;

	// Restoring divider: one quotient bit per cycle.
	localparam int DIV_W  = ACC_W + BIAS_FRAC_BITS;
	localparam int STEP_W = $clog2(DIV_W);

	localparam int ACCEL_SHIFT = 16;
	localparam int GYRO_SHIFT  = 16 + BIAS_FRAC_BITS;

	// 0.000244 * 2^32 and 0.07 * 2^24.
	localparam logic [MUL_KW-1:0] ACCEL_K = MUL_KW'(1047972);
	localparam logic [MUL_KW-1:0] GYRO_K  = MUL_KW'(1174405);

	localparam logic [COUNT_BITS-1:0] CAL_COUNT_RESET = COUNT_BITS'(1000);

	localparam logic [1:0] OP_MEASURE = 2'd0;
	localparam logic [1:0] OP_CAL     = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	localparam logic [1:0] ST_MEASURED = 2'd0;
	localparam logic [1:0] ST_SAMPLE   = 2'd1;
	localparam logic [1:0] ST_DONE     = 2'd2;
	localparam logic [1:0] ST_CLEARED  = 2'd3;

	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} ser_ctl_t;

endpackage

`default_nettype wire

// ===== src/imu_gyro_bias_calibrate_scale.sv =====
// ----------------------------------------------------------------------------
// IMU gyro bias calibration and scaling
// Input beats carry an operation and one raw six-axis sample; each input
// beat yields exactly one output beat. A measure beat gives accel in units of
// 2^-16 g and bias-corrected gyro in units of 2^-8 dps, both rounded. A
// calibration beat adds the gyro counts to per-axis sums; the beat that
// reaches calibration_count divides the sums by the sample count to form
// the bias. A clear beat zeroes bias, sums and sample count.
// A measure beat runs 25 steps of the bit-serial multipliers and the
// calibration beat that closes a run 40 steps of the bit-serial dividers
// before its result is loaded; other beats go straight to the output
// register. in_ready is high only between items, so the block takes no
// new item until the last one has been loaded into the output register.
// The result sits in an output register; in_ready returns while it waits to
// be taken. If the receiver stalls with a result still held, the next result
// waits inside the block and in_ready stays low until the register frees.
// Reset clears bias, sums and count, and sets calibration_count to 1000.
// cfg_we writes calibration_count at once; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "imu_gyro_bias_calibrate_scale_macros.svh"

module imu_gyro_bias_calibrate_scale (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,

	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic signed [15:0]  accel_x_raw,
	input  logic signed [15:0]  accel_y_raw,
	input  logic signed [15:0]  accel_z_raw,
	input  logic signed [15:0]  gyro_x_raw,
	input  logic signed [15:0]  gyro_y_raw,
	input  logic signed [15:0]  gyro_z_raw,

	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [19:0]  accel_x_g,
	output logic signed [19:0]  accel_y_g,
	output logic signed [19:0]  accel_z_g,
	output logic signed [21:0]  gyro_x_dps,
	output logic signed [21:0]  gyro_y_dps,
	output logic signed [21:0]  gyro_z_dps,
	output logic [1:0]          status
);

	localparam int RAW_W   = imu_gbcs_pkg::RAW_W;
	localparam int CB      = imu_gbcs_pkg::COUNT_BITS;
	localparam int ACC_W   = imu_gbcs_pkg::ACC_W;
	localparam int BIAS_W  = imu_gbcs_pkg::BIAS_W;
	localparam int FRAC    = imu_gbcs_pkg::BIAS_FRAC_BITS;
	localparam int MUL_N   = imu_gbcs_pkg::MUL_N;
	localparam int MUL_PW  = imu_gbcs_pkg::MUL_PW;
	localparam int DIV_W   = imu_gbcs_pkg::DIV_W;
	localparam int STEP_W  = imu_gbcs_pkg::STEP_W;
	localparam int ACCEL_W = imu_gbcs_pkg::ACCEL_W;
	localparam int GYRO_W  = imu_gbcs_pkg::GYRO_W;
	localparam int A_SH    = imu_gbcs_pkg::ACCEL_SHIFT;
	localparam int G_SH    = imu_gbcs_pkg::GYRO_SHIFT;
	localparam int A_RW    = MUL_PW - A_SH + 1;
	localparam int G_RW    = MUL_PW - G_SH + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_PREP = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_HOLD = 3'd4;

	// floor(p / 2^s + 1/2), then saturate to the field.
	function automatic logic signed [ACCEL_W-1:0] round_sat_accel(
		input logic signed [MUL_PW-1:0] p
	);
		logic [A_RW-1:0] r;
		r = {p[MUL_PW-1], p[MUL_PW-1:A_SH]} + {{(A_RW-1){1'b0}}, p[A_SH-1]};
		if (!r[A_RW-1] && (|r[A_RW-2:ACCEL_W-1])) begin
			round_sat_accel = {1'b0, {(ACCEL_W-1){1'b1}}};
		end else if (r[A_RW-1] && !(&r[A_RW-2:ACCEL_W-1])) begin
			round_sat_accel = {1'b1, {(ACCEL_W-1){1'b0}}};
		end else begin
			round_sat_accel = r[ACCEL_W-1:0];
		end
	endfunction

	function automatic logic signed [GYRO_W-1:0] round_sat_gyro(
		input logic signed [MUL_PW-1:0] p
	);
		logic [G_RW-1:0] r;
		r = {p[MUL_PW-1], p[MUL_PW-1:G_SH]} + {{(G_RW-1){1'b0}}, p[G_SH-1]};
		if (!r[G_RW-1] && (|r[G_RW-2:GYRO_W-1])) begin
			round_sat_gyro = {1'b0, {(GYRO_W-1){1'b1}}};
		end else if (r[G_RW-1] && !(&r[G_RW-2:GYRO_W-1])) begin
			round_sat_gyro = {1'b1, {(GYRO_W-1){1'b0}}};
		end else begin
			round_sat_gyro = r[GYRO_W-1:0];
		end
	endfunction

	// Signed bias from quotient magnitude, saturated to the bias width.
	function automatic logic [BIAS_W-1:0] bias_from_quot(
		input logic [DIV_W-1:0] q,
		input logic             neg
	);
		logic big;
		big = |q[DIV_W-1:BIAS_W-1];
		if (neg) begin
			bias_from_quot = big ? {1'b1, {(BIAS_W-1){1'b0}}} : -q[BIAS_W-1:0];
		end else begin
			bias_from_quot = big ? {1'b0, {(BIAS_W-1){1'b1}}} : q[BIAS_W-1:0];
		end
	endfunction

	logic [2:0]        state_q;
	logic [STEP_W-1:0] cnt_q;
	logic [CB-1:0]     count_q;
	logic [CB-1:0]     samples_q;
	logic [ACC_W-1:0]  acc_q [3];
	logic [BIAS_W-1:0] bias_q [3];
	logic [2:0]        neg_q;
	logic [1:0]        pend_q;
	logic              meas_q;
	logic              out_valid_q;

	logic signed [RAW_W-1:0]  gyro_in [3];
	logic signed [RAW_W-1:0]  accel_in [3];
	logic [ACC_W-1:0]         acc_new [3];
	logic [CB-1:0]            samp_inc;
	logic                     accept;
	logic                     is_meas;
	logic                     cal_end;
	logic                     out_load;
	logic                     mul_last_step;
	logic                     div_last_step;

	logic signed [MUL_N-1:0]  mul_in [6];
	logic signed [MUL_PW-1:0] mul_prod [6];
	logic [DIV_W-1:0]         div_dividend [3];
	logic [DIV_W-1:0]         div_quot [3];
	imu_gbcs_pkg::ser_ctl_t   mul_ctl;
	imu_gbcs_pkg::ser_ctl_t   div_ctl;

	assign accel_in[0] = accel_x_raw;
	assign accel_in[1] = accel_y_raw;
	assign accel_in[2] = accel_z_raw;
	assign gyro_in[0]  = gyro_x_raw;
	assign gyro_in[1]  = gyro_y_raw;
	assign gyro_in[2]  = gyro_z_raw;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_meas  = (op != imu_gbcs_pkg::OP_CAL) && (op != imu_gbcs_pkg::OP_CLEAR);

	always_comb begin
		samp_inc = samples_q + CB'(1);
		if (samp_inc == '0) begin
			samp_inc = CB'(1);
		end
	end
	assign cal_end = (samp_inc >= count_q);

	assign mul_last_step = (cnt_q == STEP_W'(MUL_N - 1));
	assign div_last_step = (cnt_q == STEP_W'(DIV_W - 1));
	assign out_load      = (state_q == S_HOLD) && (!out_valid_q || out_ready);

	assign mul_ctl.load = accept && is_meas;
	assign mul_ctl.step = (state_q == S_MUL);
	assign mul_ctl.last = mul_last_step;
	assign div_ctl.load = (state_q == S_PREP);
	assign div_ctl.step = (state_q == S_DIV);
	assign div_ctl.last = div_last_step;

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_axis
			assign acc_new[g] = acc_q[g] + {{(ACC_W-RAW_W){gyro_in[g][RAW_W-1]}}, gyro_in[g]};

			assign mul_in[g] = {{(MUL_N-RAW_W){accel_in[g][RAW_W-1]}}, accel_in[g]};
			// Raw gyro in bias units, minus the bias, both sign-extended by one bit.
			assign mul_in[g+3] = {gyro_in[g][RAW_W-1], gyro_in[g], {FRAC{1'b0}}}
				- {bias_q[g][BIAS_W-1], bias_q[g]};

			assign div_dividend[g] = {(acc_q[g][ACC_W-1] ? -acc_q[g] : acc_q[g]),
				{FRAC{1'b0}}};

			imu_gbcs_ser_mul u_mul_accel (
				.clk    (clk),
				.ctl    (mul_ctl),
				.k      (imu_gbcs_pkg::ACCEL_K),
				.mplier (mul_in[g]),
				.prod   (mul_prod[g])
			);

			imu_gbcs_ser_mul u_mul_gyro (
				.clk    (clk),
				.ctl    (mul_ctl),
				.k      (imu_gbcs_pkg::GYRO_K),
				.mplier (mul_in[g+3]),
				.prod   (mul_prod[g+3])
			);

			imu_gbcs_ser_div u_div (
				.clk      (clk),
				.ctl      (div_ctl),
				.dividend (div_dividend[g]),
				.divisor  (samples_q),
				.quot     (div_quot[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= imu_gbcs_pkg::CAL_COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			samples_q <= '0;
			neg_q     <= '0;
			pend_q    <= imu_gbcs_pkg::ST_MEASURED;
			meas_q    <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc_q[i]  <= '0;
				bias_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (op == imu_gbcs_pkg::OP_CLEAR) begin
							samples_q <= '0;
							for (int i = 0; i < 3; i++) begin
								acc_q[i]  <= '0;
								bias_q[i] <= '0;
							end
							pend_q  <= imu_gbcs_pkg::ST_CLEARED;
							meas_q  <= 1'b0;
							state_q <= S_HOLD;
						end else if (op == imu_gbcs_pkg::OP_CAL) begin
							samples_q <= samp_inc;
							for (int i = 0; i < 3; i++) begin
								acc_q[i] <= acc_new[i];
							end
							meas_q <= 1'b0;
							if (cal_end) begin
								pend_q  <= imu_gbcs_pkg::ST_DONE;
								state_q <= S_PREP;
							end else begin
								pend_q  <= imu_gbcs_pkg::ST_SAMPLE;
								state_q <= S_HOLD;
							end
						end else begin
							pend_q  <= imu_gbcs_pkg::ST_MEASURED;
							meas_q  <= 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + STEP_W'(1);
					if (mul_last_step) begin
						state_q <= S_HOLD;
					end
				end
				S_PREP: begin
					// The dividers have taken the sums and the count this cycle.
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= acc_q[i][ACC_W-1];
						acc_q[i] <= '0;
					end
					samples_q <= '0;
					cnt_q     <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + STEP_W'(1);
					if (div_last_step) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_load) begin
						if (pend_q == imu_gbcs_pkg::ST_DONE) begin
							for (int i = 0; i < 3; i++) begin
								bias_q[i] <= bias_from_quot(div_quot[i], neg_q[i]);
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status <= pend_q;
			if (meas_q) begin
				accel_x_g  <= round_sat_accel(mul_prod[0]);
				accel_y_g  <= round_sat_accel(mul_prod[1]);
				accel_z_g  <= round_sat_accel(mul_prod[2]);
				gyro_x_dps <= round_sat_gyro(mul_prod[3]);
				gyro_y_dps <= round_sat_gyro(mul_prod[4]);
				gyro_z_dps <= round_sat_gyro(mul_prod[5]);
			end else begin
				accel_x_g  <= '0;
				accel_y_g  <= '0;
				accel_z_g  <= '0;
				gyro_x_dps <= '0;
				gyro_y_dps <= '0;
				gyro_z_dps <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`IMU_ASSERT_NEXT(a_clear_zeroes_state, clk, arst_n, accept && (op == imu_gbcs_pkg::OP_CLEAR), (samples_q == '0) && (bias_q[0] == '0) && (bias_q[1] == '0) && (bias_q[2] == '0) && (acc_q[0] == '0) && (acc_q[1] == '0) && (acc_q[2] == '0))
	`IMU_ASSERT_NOW(a_div_sums_cleared, clk, arst_n, state_q == S_DIV, (samples_q == '0) && (acc_q[0] == '0) && (acc_q[1] == '0) && (acc_q[2] == '0))
	`IMU_ASSERT_NEXT(a_stalled_result_kept, clk, arst_n, (state_q == S_HOLD) && out_valid_q && !out_ready, (state_q == S_HOLD) && out_valid_q)
	`IMU_ASSERT_NOW(a_result_from_hold, clk, arst_n, $rose(out_valid_q), $past(state_q == S_HOLD))

endmodule

`default_nettype wire

// ===== src/imu_gbcs_ser_mul.sv =====
// ----------------------------------------------------------------------------
// IMU gyro bias calibration: bit-serial multiplier
// Signed operand times unsigned constant, one operand bit per cycle, with
// the product shifting into the operand register from the top.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_gbcs_ser_mul (
	input  logic                                     clk,
	input  imu_gbcs_pkg::ser_ctl_t                   ctl,
	input  logic        [imu_gbcs_pkg::MUL_KW-1:0]   k,
	input  logic signed [imu_gbcs_pkg::MUL_N-1:0]    mplier,
	output logic signed [imu_gbcs_pkg::MUL_PW-1:0]   prod
);

	logic signed [imu_gbcs_pkg::MUL_KW:0]   hi_q;
	logic        [imu_gbcs_pkg::MUL_N-1:0]  lo_q;
	logic signed [imu_gbcs_pkg::MUL_KW+1:0] addend;
	logic signed [imu_gbcs_pkg::MUL_KW+1:0] sum;

	// The operand's top bit carries negative weight, so the last step subtracts.
	always_comb begin
		addend = signed'({2'b00, k});
		if (ctl.last) begin
			addend = -addend;
		end
		if (!lo_q[0]) begin
			addend = '0;
		end
		sum = {hi_q[imu_gbcs_pkg::MUL_KW], hi_q} + addend;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hi_q <= '0;
			lo_q <= mplier;
		end else if (ctl.step) begin
			hi_q <= sum[imu_gbcs_pkg::MUL_KW+1:1];
			lo_q <= {sum[0], lo_q[imu_gbcs_pkg::MUL_N-1:1]};
		end
	end

	assign prod = {hi_q, lo_q};

endmodule

`default_nettype wire

// ===== src/imu_gbcs_ser_div.sv =====
// ----------------------------------------------------------------------------
// IMU gyro bias calibration: bit-serial restoring divider
// Unsigned dividend over unsigned divisor, one quotient bit per cycle; the
// dividend register fills with quotient bits as it empties.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_gbcs_ser_div (
	input  logic                                   clk,
	input  imu_gbcs_pkg::ser_ctl_t                 ctl,
	input  logic [imu_gbcs_pkg::DIV_W-1:0]         dividend,
	input  logic [imu_gbcs_pkg::COUNT_BITS-1:0]    divisor,
	output logic [imu_gbcs_pkg::DIV_W-1:0]         quot
);

	localparam int CB = imu_gbcs_pkg::COUNT_BITS;
	localparam int DW = imu_gbcs_pkg::DIV_W;

	logic [CB-1:0] rem_q;
	logic [CB-1:0] d_q;
	logic [DW-1:0] q_q;
	logic [CB:0]   shifted;
	logic [CB+1:0] diff;
	logic          fits;

	always_comb begin
		shifted = {rem_q, q_q[DW-1]};
		diff    = {1'b0, shifted} - {2'b00, d_q};
		fits    = !diff[CB+1];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= '0;
			d_q   <= divisor;
			q_q   <= dividend;
		end else if (ctl.step) begin
			rem_q <= fits ? diff[CB-1:0] : shifted[CB-1:0];
			q_q   <= {q_q[DW-2:0], fits};
		end
	end

	assign quot = q_q;

endmodule

`default_nettype wire
